// ----- sv/assert_macros.svh -----
// assertion helpers used by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, ck, rstn, expr) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (expr)) \
    else $error("assertion failed: always");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next cycle");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: same cycle");

`endif

// ----- sv/bfpa_pkg.sv -----
`timescale 1ns / 1ps

package bfpa_pkg;

  localparam int ID_W  = 8;
  localparam int REQ_W = 16;
  localparam int SUM_W = 20;

  typedef logic [ID_W-1:0]  id_t;
  typedef logic [REQ_W-1:0] req_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [1:0]       code_t;

  // operation codes
  localparam code_t FN_CREATE = 2'd0;
  localparam code_t FN_ALLOC  = 2'd1;
  localparam code_t FN_FREE   = 2'd2;

  // result status codes
  localparam code_t ST_OK       = 2'd0;
  localparam code_t ST_NOFIT    = 2'd1;
  localparam code_t ST_NOTFOUND = 2'd2;
  localparam code_t ST_FULL     = 2'd3;

endpackage

// ----- sv/bfpa_ram.sv -----
`timescale 1ns / 1ps

module bfpa_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/best_fit_partition_allocator.sv -----
`timescale 1ns / 1ps
// channel | ports                                         | direction
// input   | in_valid, in_stall, in_func, in_part_id,       | into block
//         | in_req_size                                    |
// result  | out_valid, out_stall, out_status,              | out of block
//         | out_granted_id, out_total_size, out_free_size, |
//         | out_used_size                                  |
//
// allocate and free walk the slot table one entry a cycle through the table ram
// (one read port, registered read); a free stops early at its first match.
// create and unknown ops skip the walk: they go straight to update, then finish.
// rst_n is synchronous, active low: empties the table, clears the sums.
// in_stall is high from a transfer until its result sits in the output register;
// a stalled output holds the block in its last step until the result is taken.

`include "assert_macros.svh"

module best_fit_partition_allocator #(
  parameter int SLOTS     = 16,
  parameter int SIZE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bfpa_pkg::code_t       in_func,
  input  bfpa_pkg::id_t         in_part_id,
  input  bfpa_pkg::req_t        in_req_size,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bfpa_pkg::code_t       out_status,
  output bfpa_pkg::id_t         out_granted_id,
  output bfpa_pkg::sum_t        out_total_size,
  output bfpa_pkg::sum_t        out_free_size,
  output bfpa_pkg::sum_t        out_used_size
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int RW = bfpa_pkg::ID_W + SIZE_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_FINISH
  } state_t;

  typedef logic [SIZE_BITS-1:0] size_t;

  // sequencer and operand registers
  state_t          state_r, state_nxt;
  bfpa_pkg::code_t func_r, func_nxt;
  bfpa_pkg::id_t   id_r, id_nxt;
  size_t           need_r, need_nxt;

  // scan registers
  logic [CW-1:0]   idx_r, idx_nxt;
  logic            rd_pend_r, rd_pend_nxt;
  logic [AW-1:0]   rd_slot_r, rd_slot_nxt;
  logic            found_r, found_nxt;
  logic [AW-1:0]   best_slot_r, best_slot_nxt;
  size_t           best_size_r, best_size_nxt;
  bfpa_pkg::id_t   best_id_r, best_id_nxt;

  // table bookkeeping
  logic [CW-1:0]   count_r, count_nxt;
  logic [SLOTS-1:0] used_r, used_nxt;
  bfpa_pkg::sum_t  sum_total_r, sum_total_nxt;
  bfpa_pkg::sum_t  sum_used_r, sum_used_nxt;

  // staged result
  bfpa_pkg::code_t status_r, status_nxt;
  bfpa_pkg::id_t   granted_r, granted_nxt;

  // output register
  logic            out_valid_r, out_valid_nxt;
  bfpa_pkg::code_t out_status_r, out_status_nxt;
  bfpa_pkg::id_t   out_granted_r, out_granted_nxt;
  bfpa_pkg::sum_t  out_total_r, out_total_nxt;
  bfpa_pkg::sum_t  out_free_r, out_free_nxt;
  bfpa_pkg::sum_t  out_used_r, out_used_nxt;

  // table ram
  logic            ram_we;
  logic            ram_re;
  logic [RW-1:0]   ram_rdata;
  size_t           rd_size;
  bfpa_pkg::id_t   rd_id;

  // shared adder
  size_t           op_size;
  bfpa_pkg::sum_t  op_ext;
  size_t           size_in;
  bfpa_pkg::sum_t  add_a, add_b, add_y;
  logic            add_sub;

  logic            issue;
  logic            rd_used;
  logic            alloc_hit;
  logic            free_hit;

  // request size trimmed or widened to the stored size width
  if (SIZE_BITS <= bfpa_pkg::REQ_W) begin : g_in_trim
    assign size_in = in_req_size[SIZE_BITS-1:0];
  end else begin : g_in_ext
    assign size_in = {{(SIZE_BITS - bfpa_pkg::REQ_W){1'b0}}, in_req_size};
  end

  // partition size brought to the sum width, wrapping like the sums
  if (SIZE_BITS <= bfpa_pkg::SUM_W) begin : g_op_ext
    assign op_ext = {{(bfpa_pkg::SUM_W - SIZE_BITS){1'b0}}, op_size};
  end else begin : g_op_trim
    assign op_ext = op_size[bfpa_pkg::SUM_W-1:0];
  end

  bfpa_ram #(
    .WIDTH (RW),
    .DEPTH (SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({id_r, need_r}),
    .re    (ram_re),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_size = ram_rdata[SIZE_BITS-1:0];
  assign rd_id   = ram_rdata[RW-1:SIZE_BITS];

  // one read issued per scan cycle while slots remain
  assign issue  = (state_r == S_SCAN) && (idx_r < count_r);
  assign ram_re = issue;

  // compare the slot that came back from the ram last cycle
  assign rd_used   = used_r[rd_slot_r];
  assign alloc_hit = rd_pend_r && !rd_used && (rd_size >= need_r) &&
                     (!found_r || (rd_size < best_size_r));
  assign free_hit  = rd_pend_r && rd_used && (rd_id == id_r);

  // create adds its own size, allocate and free the chosen slot's size
  assign op_size = (func_r == bfpa_pkg::FN_CREATE) ? need_r : best_size_r;

  // one adder: sum update in the update step, free space in the finish step
  always_comb begin
    add_a   = sum_total_r;
    add_b   = sum_used_r;
    add_sub = 1'b1;
    if (state_r == S_UPDATE) begin
      add_a   = (func_r == bfpa_pkg::FN_CREATE) ? sum_total_r : sum_used_r;
      add_b   = op_ext;
      add_sub = (func_r == bfpa_pkg::FN_FREE);
    end
    add_y = add_a + (add_b ^ {bfpa_pkg::SUM_W{add_sub}}) +
            bfpa_pkg::sum_t'(add_sub);
  end

  always_comb begin
    state_nxt       = state_r;
    func_nxt        = func_r;
    id_nxt          = id_r;
    need_nxt        = need_r;
    idx_nxt         = idx_r;
    rd_pend_nxt     = rd_pend_r;
    rd_slot_nxt     = rd_slot_r;
    found_nxt       = found_r;
    best_slot_nxt   = best_slot_r;
    best_size_nxt   = best_size_r;
    best_id_nxt     = best_id_r;
    count_nxt       = count_r;
    used_nxt        = used_r;
    sum_total_nxt   = sum_total_r;
    sum_used_nxt    = sum_used_r;
    status_nxt      = status_r;
    granted_nxt     = granted_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_granted_nxt = out_granted_r;
    out_total_nxt   = out_total_r;
    out_free_nxt    = out_free_r;
    out_used_nxt    = out_used_r;
    ram_we          = 1'b0;

    // output register drains on a transfer
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt    = in_func;
          id_nxt      = in_part_id;
          need_nxt    = size_in;
          idx_nxt     = '0;
          found_nxt   = 1'b0;
          rd_pend_nxt = 1'b0;
          if (in_func == bfpa_pkg::FN_ALLOC || in_func == bfpa_pkg::FN_FREE) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_UPDATE;
          end
        end
      end

      S_SCAN: begin
        rd_pend_nxt = issue;
        rd_slot_nxt = idx_r[AW-1:0];
        if (issue) begin
          idx_nxt = idx_r + CW'(1);
        end
        if (func_r == bfpa_pkg::FN_ALLOC) begin
          // best fit: keep the smallest size that is large enough
          if (alloc_hit) begin
            found_nxt     = 1'b1;
            best_slot_nxt = rd_slot_r;
            best_size_nxt = rd_size;
            best_id_nxt   = rd_id;
          end
          if (!issue) begin
            state_nxt = S_UPDATE;
          end
        end else begin
          // free: first used slot with a matching id ends the walk
          if (free_hit) begin
            found_nxt     = 1'b1;
            best_slot_nxt = rd_slot_r;
            best_size_nxt = rd_size;
            rd_pend_nxt   = 1'b0;
            state_nxt     = S_UPDATE;
          end else if (!issue) begin
            state_nxt = S_UPDATE;
          end
        end
      end

      S_UPDATE: begin
        status_nxt  = bfpa_pkg::ST_OK;
        granted_nxt = '0;
        case (func_r)
          bfpa_pkg::FN_CREATE: begin
            if (count_r == CW'(SLOTS)) begin
              status_nxt = bfpa_pkg::ST_FULL;
            end else begin
              ram_we                     = 1'b1;
              used_nxt[count_r[AW-1:0]]  = 1'b0;
              count_nxt                  = count_r + CW'(1);
              sum_total_nxt              = add_y;
            end
          end
          bfpa_pkg::FN_ALLOC: begin
            if (found_r) begin
              used_nxt[best_slot_r] = 1'b1;
              sum_used_nxt          = add_y;
              granted_nxt           = best_id_r;
            end else begin
              status_nxt = bfpa_pkg::ST_NOFIT;
            end
          end
          bfpa_pkg::FN_FREE: begin
            if (found_r) begin
              used_nxt[best_slot_r] = 1'b0;
              sum_used_nxt          = add_y;
            end else begin
              status_nxt = bfpa_pkg::ST_NOTFOUND;
            end
          end
          default: begin
            // unknown op: no change, report the sums
          end
        endcase
        state_nxt = S_FINISH;
      end

      S_FINISH: begin
        // wait for room in the output register
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_granted_nxt = granted_r;
          out_total_nxt   = sum_total_r;
          out_free_nxt    = add_y;
          out_used_nxt    = sum_used_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_pend_r   <= 1'b0;
      count_r     <= '0;
      used_r      <= '0;
      sum_total_r <= '0;
      sum_used_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      count_r     <= count_nxt;
      used_r      <= used_nxt;
      sum_total_r <= sum_total_nxt;
      sum_used_r  <= sum_used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r        <= func_nxt;
    id_r          <= id_nxt;
    need_r        <= need_nxt;
    idx_r         <= idx_nxt;
    rd_slot_r     <= rd_slot_nxt;
    found_r       <= found_nxt;
    best_slot_r   <= best_slot_nxt;
    best_size_r   <= best_size_nxt;
    best_id_r     <= best_id_nxt;
    status_r      <= status_nxt;
    granted_r     <= granted_nxt;
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
    out_total_r   <= out_total_nxt;
    out_free_r    <= out_free_nxt;
    out_used_r    <= out_used_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_granted_id = out_granted_r;
  assign out_total_size = out_total_r;
  assign out_free_size  = out_free_r;
  assign out_used_size  = out_used_r;

  // a transfer in makes the block busy on the next cycle
  `ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && !in_stall, in_stall)
  // the table never holds more partitions than it has slots
  `ASSERT_ALWAYS(a_count_range, clk, rst_n, count_r <= CW'(SLOTS))
  // the scan index never runs past the filled part of the table
  `ASSERT_SAME(a_scan_bound, clk, rst_n, state_r == S_SCAN, idx_r <= count_r)
  // a granted id only comes with a successful result
  `ASSERT_SAME(a_grant_ok, clk, rst_n, out_valid && (out_status != bfpa_pkg::ST_OK),
               out_granted_id == '0)

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int SLOTS = 16;
  localparam int SIZE_BITS = 16;
  localparam bfpa_pkg::req_t SIZE_MASK = bfpa_pkg::req_t'((64'd1 << SIZE_BITS) - 64'd1);
  // the package names only three operations; the fourth code is a no-op
  localparam bfpa_pkg::code_t FN_UNKNOWN = 2'd3;
  localparam int RANDOM_OPS = 1675;
  // quiet cycles allowed between transfers before the watchdog ends the run
  localparam int QUIET_LIMIT = 2000;
  // the tail wait scales with the table size
  localparam int TAIL_CYCLES = 2 * (SLOTS + 4);
  localparam int PLAN_ROWS = 26;

  // one result transfer
  typedef struct packed {
    bfpa_pkg::code_t status;
    bfpa_pkg::id_t   granted_id;
    bfpa_pkg::sum_t  total_size;
    bfpa_pkg::sum_t  free_size;
    bfpa_pkg::sum_t  used_size;
  } report_t;

  // one directed request, with the result typed in where it is obvious
  typedef struct packed {
    bfpa_pkg::code_t func;
    bfpa_pkg::id_t   part_id;
    bfpa_pkg::req_t  req_size;
    logic            typed;
    report_t         want;
  } plan_row_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  bfpa_pkg::code_t in_func = bfpa_pkg::FN_CREATE;
  bfpa_pkg::id_t   in_part_id = '0;
  bfpa_pkg::req_t  in_req_size = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  bfpa_pkg::code_t out_status;
  bfpa_pkg::id_t   out_granted_id;
  bfpa_pkg::sum_t  out_total_size;
  bfpa_pkg::sum_t  out_free_size;
  bfpa_pkg::sum_t  out_used_size;

  // shadow copy of the partition table
  bfpa_pkg::id_t  part_ident [SLOTS];
  bfpa_pkg::req_t part_size [SLOTS];
  bit             part_busy [SLOTS];
  int             part_count = 0;
  bfpa_pkg::sum_t total_acc = '0;
  bfpa_pkg::sum_t used_acc = '0;

  // results still owed by the block, oldest first
  report_t pending_reports[$];
  report_t head;
  int      mismatches = 0;
  int      rx_wait = 0;
  // burst modes switch the random idling off for a stretch
  bit      tx_burst = 1'b0;
  bit      rx_burst = 1'b0;

  // directed part: empty-table errors, size extremes, table fill with duplicate ids,
  // table full, best-fit tie and duplicate-id release
  plan_row_t plan [PLAN_ROWS] = '{
    // empty table: nothing to free, nothing fits, unknown op reports zero sums
    '{bfpa_pkg::FN_FREE,   8'd5,   16'd0,     1'b1,
      '{bfpa_pkg::ST_NOTFOUND, 8'd0, 20'd0, 20'd0, 20'd0}},
    '{bfpa_pkg::FN_ALLOC,  8'd0,   16'd0,     1'b1,
      '{bfpa_pkg::ST_NOFIT, 8'd0, 20'd0, 20'd0, 20'd0}},
    '{FN_UNKNOWN,          8'd255, 16'd65535, 1'b1,
      '{bfpa_pkg::ST_OK, 8'd0, 20'd0, 20'd0, 20'd0}},
    // smallest and largest partitions
    '{bfpa_pkg::FN_CREATE, 8'd0,   16'd0,     1'b1,
      '{bfpa_pkg::ST_OK, 8'd0, 20'd0, 20'd0, 20'd0}},
    '{bfpa_pkg::FN_CREATE, 8'd255, 16'd65535, 1'b1,
      '{bfpa_pkg::ST_OK, 8'd0, 20'd65535, 20'd65535, 20'd0}},
    // a zero request fits the zero-size partition best
    '{bfpa_pkg::FN_ALLOC,  8'd255, 16'd0,     1'b1,
      '{bfpa_pkg::ST_OK, 8'd0, 20'd65535, 20'd65535, 20'd0}},
    '{bfpa_pkg::FN_ALLOC,  8'd0,   16'd65535, 1'b1,
      '{bfpa_pkg::ST_OK, 8'd255, 20'd65535, 20'd0, 20'd65535}},
    '{bfpa_pkg::FN_FREE,   8'd255, 16'd0,     1'b1,
      '{bfpa_pkg::ST_OK, 8'd0, 20'd65535, 20'd65535, 20'd0}},
    // fill the rest of the table; two equal partitions share id 7, id 0 repeats
    '{bfpa_pkg::FN_CREATE, 8'd7,   16'd100,   1'b0, '0},
    '{bfpa_pkg::FN_CREATE, 8'd7,   16'd100,   1'b0, '0},
    '{bfpa_pkg::FN_CREATE, 8'd1,   16'd1,     1'b0, '0},
    '{bfpa_pkg::FN_CREATE, 8'd2,   16'd255,   1'b0, '0},
    '{bfpa_pkg::FN_CREATE, 8'd3,   16'd256,   1'b0, '0},
    '{bfpa_pkg::FN_CREATE, 8'd4,   16'd1000,  1'b0, '0},
    '{bfpa_pkg::FN_CREATE, 8'd5,   16'd4095,  1'b0, '0},
    '{bfpa_pkg::FN_CREATE, 8'd6,   16'd4096,  1'b0, '0},
    '{bfpa_pkg::FN_CREATE, 8'd128, 16'd12345, 1'b0, '0},
    '{bfpa_pkg::FN_CREATE, 8'd254, 16'd32767, 1'b0, '0},
    '{bfpa_pkg::FN_CREATE, 8'd0,   16'd32768, 1'b0, '0},
    '{bfpa_pkg::FN_CREATE, 8'd9,   16'd40000, 1'b0, '0},
    '{bfpa_pkg::FN_CREATE, 8'd8,   16'd65534, 1'b0, '0},
    '{bfpa_pkg::FN_CREATE, 8'd170, 16'd500,   1'b0, '0},
    // table full
    '{bfpa_pkg::FN_CREATE, 8'd85,  16'd777,   1'b0, '0},
    // tie between the two 100s goes to the lower slot, then the upper one
    '{bfpa_pkg::FN_ALLOC,  8'd0,   16'd50,    1'b0, '0},
    '{bfpa_pkg::FN_ALLOC,  8'd0,   16'd50,    1'b0, '0},
    // duplicate id: the lower used slot is released
    '{bfpa_pkg::FN_FREE,   8'd7,   16'd0,     1'b0, '0}
  };

  best_fit_partition_allocator #(
    .SLOTS     (SLOTS),
    .SIZE_BITS (SIZE_BITS)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_part_id     (in_part_id),
    .in_req_size    (in_req_size),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_granted_id (out_granted_id),
    .out_total_size (out_total_size),
    .out_free_size  (out_free_size),
    .out_used_size  (out_used_size)
  );

  always #5 clk = ~clk;

  // applies one request to the shadow table and returns the result it owes
  function automatic report_t apply_partition_op(bfpa_pkg::code_t fn, bfpa_pkg::id_t ident,
                                                 bfpa_pkg::req_t size_in);
    report_t        r;
    bfpa_pkg::req_t size;
    int             pick;
    size = size_in & SIZE_MASK;
    r = '0;
    r.status = bfpa_pkg::ST_OK;
    pick = -1;
    case (fn)
      bfpa_pkg::FN_CREATE: begin
        if (part_count >= SLOTS) begin
          r.status = bfpa_pkg::ST_FULL;
        end else begin
          part_ident[part_count] = ident;
          part_size[part_count] = size;
          part_busy[part_count] = 1'b0;
          part_count++;
          total_acc = total_acc + bfpa_pkg::sum_t'(size);
        end
      end
      bfpa_pkg::FN_ALLOC: begin
        // smallest free partition that fits, lowest slot on a tie
        for (int i = 0; i < part_count; i++) begin
          if (!part_busy[i] && part_size[i] >= size &&
              (pick < 0 || part_size[i] < part_size[pick])) begin
            pick = i;
          end
        end
        if (pick < 0) begin
          r.status = bfpa_pkg::ST_NOFIT;
        end else begin
          part_busy[pick] = 1'b1;
          used_acc = used_acc + bfpa_pkg::sum_t'(part_size[pick]);
          r.granted_id = part_ident[pick];
        end
      end
      bfpa_pkg::FN_FREE: begin
        // first used slot with a matching id
        for (int i = 0; i < part_count; i++) begin
          if (pick < 0 && part_busy[i] && part_ident[i] == ident) begin
            pick = i;
          end
        end
        if (pick < 0) begin
          r.status = bfpa_pkg::ST_NOTFOUND;
        end else begin
          part_busy[pick] = 1'b0;
          used_acc = used_acc - bfpa_pkg::sum_t'(part_size[pick]);
        end
      end
      default: begin
      end
    endcase
    r.total_size = total_acc;
    r.free_size = total_acc - used_acc;
    r.used_size = used_acc;
    return r;
  endfunction

  task automatic check_field(string name, logic [19:0] expv, logic [19:0] actv);
    if (actv !== expv) begin
      $display("%0t: %s expected %0d got %0d", $time, name, expv, actv);
      mismatches++;
    end
  endtask

  // drives one request and holds it until the transfer; valid stays high when
  // the next request follows with no gap
  task automatic issue_op(bfpa_pkg::code_t fn, bfpa_pkg::id_t ident, bfpa_pkg::req_t size,
                          bit typed, report_t want);
    report_t owed;
    int      gap;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= fn;
    in_part_id <= ident;
    in_req_size <= size;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    // transfer taken at this edge: the table moves on in the same order
    owed = apply_partition_op(fn, ident, size);
    pending_reports.insert(pending_reports.size(), typed ? want : owed);
    if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
  endtask

  // result side: check each transfer against the oldest owed result, then
  // draw a fresh stall that runs down whether or not a result is waiting
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: result with nothing pending, expected none got status %0d",
                 $time, out_status);
        mismatches++;
      end else begin
        head = pending_reports.pop_front();
        check_field("status", 20'(head.status), 20'(out_status));
        check_field("granted_id", 20'(head.granted_id), 20'(out_granted_id));
        check_field("total_size", head.total_size, out_total_size);
        check_field("free_size", head.free_size, out_free_size);
        check_field("used_size", head.used_size, out_used_size);
      end
      rx_wait = rx_burst ? 0 : $urandom_range(0, 19);
      if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    out_stall <= (rx_wait != 0);
  end

  // watchdog: too long without any transfer on either side ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    report_t         none;
    bfpa_pkg::code_t fn;
    bfpa_pkg::id_t   ident;
    bfpa_pkg::req_t  size;
    bfpa_pkg::req_t  delta;
    int              roll;
    int              pick;
    int              start;
    int              idx;
    none = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      issue_op(plan[i].func, plan[i].part_id, plan[i].req_size, plan[i].typed, plan[i].want);
    end

    // the table is full from here on; random traffic mostly allocates and
    // frees against its contents, with some noise mixed in
    for (int k = 0; k < RANDOM_OPS; k++) begin
      // now and then hold off until the block has nothing owed
      if (k % 500 == 250) begin
        in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
      end
      roll = $urandom_range(0, 99);
      ident = bfpa_pkg::id_t'($urandom_range(0, 255));
      size = bfpa_pkg::req_t'($urandom_range(0, 65535));
      if (roll < 45) begin
        fn = bfpa_pkg::FN_ALLOC;
        // most requests sit at or near an existing partition size
        if (roll >= 5 && part_count > 0) begin
          pick = $urandom_range(0, part_count - 1);
          case ($urandom_range(0, 3))
            0: size = part_size[pick];
            1: begin
              delta = bfpa_pkg::req_t'($urandom_range(0, 3));
              size = (part_size[pick] > delta) ? part_size[pick] - delta : '0;
            end
            2: size = part_size[pick] + 16'd1;
            default: size = part_size[pick] >> $urandom_range(1, 8);
          endcase
        end
      end else if (roll < 85) begin
        fn = bfpa_pkg::FN_FREE;
        // mostly release something that is in use
        if (roll < 77 && part_count > 0) begin
          start = $urandom_range(0, part_count - 1);
          for (int j = 0; j < part_count; j++) begin
            idx = (start + j) % part_count;
            if (part_busy[idx]) begin
              ident = part_ident[idx];
              break;
            end
          end
        end
      end else if (roll < 93) begin
        fn = bfpa_pkg::FN_CREATE;
      end else begin
        fn = FN_UNKNOWN;
      end
      issue_op(fn, ident, size, 1'b0, none);
    end

    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    // catch any stray result after the last one owed
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
